FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the collision pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ECP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ECP_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ECP_ASSERT(lbl, clk, rstn, prop)
`define ECP_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: hdl/ecp_pkg.sv
// ----------------------------------------------------------------------------
// Collision pipeline package
// Widths, payload structs and divider sizing shared by all stages.
// ----------------------------------------------------------------------------
package ecp_pkg;
  localparam int unsigned IdW   = 8;
  localparam int unsigned PosW  = 24;
  localparam int unsigned VelW  = 16;
  localparam int unsigned MassW = 16;
  localparam int unsigned RadW  = 16;
  localparam logic [RadW-1:0] RadiusRst = 16'd2560;

  localparam int unsigned DivNW = 60;
  localparam int unsigned DivDW = 34;
  localparam int unsigned DivQW = 26;

  typedef struct packed {
    logic [IdW-1:0]   id_a;
    logic [IdW-1:0]   id_b;
    logic [PosW-1:0]  apx;
    logic [PosW-1:0]  apy;
    logic [VelW-1:0]  avx;
    logic [VelW-1:0]  avy;
    logic [MassW-1:0] am;
    logic [PosW-1:0]  bpx;
    logic [PosW-1:0]  bpy;
    logic [VelW-1:0]  bvx;
    logic [VelW-1:0]  bvy;
    logic [MassW-1:0] bm;
  } ecp_pair_t;

  typedef struct packed {
    logic [IdW-1:0]   id_a;
    logic [IdW-1:0]   id_b;
    logic [VelW-1:0]  avx;
    logic [VelW-1:0]  avy;
    logic [VelW-1:0]  bvx;
    logic [VelW-1:0]  bvy;
    logic [MassW-1:0] ma;
    logic [MassW-1:0] mb;
    logic             go;
    logic             neg_x;
    logic             neg_y;
  } ecp_side_t;

  typedef struct packed {
    logic [IdW-1:0]  id_a;
    logic [IdW-1:0]  id_b;
    logic [VelW-1:0] nax;
    logic [VelW-1:0] nay;
    logic [VelW-1:0] nbx;
    logic [VelW-1:0] nby;
    logic            bounced;
  } ecp_res_t;
endpackage

FILE: hdl/ecp_front.sv
// ----------------------------------------------------------------------------
// Collision front end
// Differences, squared distance, approach dot product, contact test and
// projection numerators, in six register stages.
// ----------------------------------------------------------------------------
module ecp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [ecp_pkg::RadW-1:0]   radius_i,
  input  ecp_pkg::ecp_pair_t         pair_i,
  output logic                       valid_o,
  output logic [ecp_pkg::DivNW-1:0]  num_x_o,
  output logic [ecp_pkg::DivNW-1:0]  num_y_o,
  output logic [ecp_pkg::DivDW-1:0]  den_o,
  output ecp_pkg::ecp_side_t         side_o
);
  import ecp_pkg::*;

  logic [5:0] v_q;

  logic signed [24:0] dx1_q, dy1_q, dx1_d, dy1_d;
  logic signed [16:0] dvx1_q, dvy1_q, dvx1_d, dvy1_d;
  logic [16:0]        twor1_q;
  ecp_side_t          side1_q, side1_d;

  logic [49:0]        sqx2_q, sqy2_q;
  logic signed [49:0] sqx_d, sqy_d;
  logic signed [41:0] px2_q, py2_q, px_d, py_d;
  logic [33:0]        tr2_q;
  logic signed [24:0] dx2_q, dy2_q;
  ecp_side_t          side2_q;

  logic [50:0]        dd3_q;
  logic signed [42:0] p3_q;
  logic [33:0]        tr3_q;
  logic signed [24:0] dx3_q, dy3_q;
  ecp_side_t          side3_q;

  logic [24:0]        adx_d, ady_d;
  logic               go_d;
  logic [33:0]        pm4_q, dd4_q;
  logic [16:0]        adx4_q, ady4_q;
  ecp_side_t          side4_q, side4_d;

  logic [33:0]        plx5_q, phx5_q, ply5_q, phy5_q, dd5_q;
  ecp_side_t          side5_q;

  logic [DivNW-1:0]   numx6_q, numy6_q;
  logic [50:0]        prx_d, pry_d;
  logic [DivDW-1:0]   dd6_q;
  ecp_side_t          side6_q;

  always_comb begin
    dx1_d  = {pair_i.apx[PosW-1], pair_i.apx} - {pair_i.bpx[PosW-1], pair_i.bpx};
    dy1_d  = {pair_i.apy[PosW-1], pair_i.apy} - {pair_i.bpy[PosW-1], pair_i.bpy};
    dvx1_d = {pair_i.bvx[VelW-1], pair_i.bvx} - {pair_i.avx[VelW-1], pair_i.avx};
    dvy1_d = {pair_i.bvy[VelW-1], pair_i.bvy} - {pair_i.avy[VelW-1], pair_i.avy};
    side1_d       = '0;
    side1_d.id_a  = pair_i.id_a;
    side1_d.id_b  = pair_i.id_b;
    side1_d.avx   = pair_i.avx;
    side1_d.avy   = pair_i.avy;
    side1_d.bvx   = pair_i.bvx;
    side1_d.bvy   = pair_i.bvy;
    side1_d.ma    = (pair_i.am == '0) ? MassW'(1) : pair_i.am;
    side1_d.mb    = (pair_i.bm == '0) ? MassW'(1) : pair_i.bm;
  end

  assign sqx_d = dx1_q * dx1_q;
  assign sqy_d = dy1_q * dy1_q;
  assign px_d  = dvx1_q * dx1_q;
  assign py_d  = dvy1_q * dy1_q;

  always_comb begin
    adx_d = dx3_q[24] ? (25'd0 - dx3_q) : dx3_q;
    ady_d = dy3_q[24] ? (25'd0 - dy3_q) : dy3_q;
    go_d  = (dd3_q <= {17'd0, tr3_q}) && !p3_q[42] && (p3_q != '0) && (dd3_q != '0);
    side4_d       = side3_q;
    side4_d.go    = go_d;
    side4_d.neg_x = dx3_q[24];
    side4_d.neg_y = dy3_q[24];
  end

  assign prx_d = {phx5_q, 17'd0} + {17'd0, plx5_q};
  assign pry_d = {phy5_q, 17'd0} + {17'd0, ply5_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q   <= dx1_d;
      dy1_q   <= dy1_d;
      dvx1_q  <= dvx1_d;
      dvy1_q  <= dvy1_d;
      twor1_q <= {radius_i, 1'b0};
      side1_q <= side1_d;

      sqx2_q  <= sqx_d;
      sqy2_q  <= sqy_d;
      px2_q   <= px_d;
      py2_q   <= py_d;
      tr2_q   <= twor1_q * twor1_q;
      dx2_q   <= dx1_q;
      dy2_q   <= dy1_q;
      side2_q <= side1_q;

      dd3_q   <= {1'b0, sqx2_q} + {1'b0, sqy2_q};
      p3_q    <= {px2_q[41], px2_q} + {py2_q[41], py2_q};
      tr3_q   <= tr2_q;
      dx3_q   <= dx2_q;
      dy3_q   <= dy2_q;
      side3_q <= side2_q;

      pm4_q   <= p3_q[33:0];
      dd4_q   <= dd3_q[33:0];
      adx4_q  <= adx_d[16:0];
      ady4_q  <= ady_d[16:0];
      side4_q <= side4_d;

      plx5_q  <= pm4_q[16:0] * adx4_q;
      phx5_q  <= pm4_q[33:17] * adx4_q;
      ply5_q  <= pm4_q[16:0] * ady4_q;
      phy5_q  <= pm4_q[33:17] * ady4_q;
      dd5_q   <= dd4_q;
      side5_q <= side4_q;

      numx6_q <= {1'b0, prx_d, 8'd0};
      numy6_q <= {1'b0, pry_d, 8'd0};
      dd6_q   <= dd5_q;
      side6_q <= side5_q;
    end
  end

  assign valid_o = v_q[5];
  assign num_x_o = numx6_q;
  assign num_y_o = numy6_q;
  assign den_o   = dd6_q;
  assign side_o  = side6_q;
endmodule

FILE: hdl/ecp_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Unsigned restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ecp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [ecp_pkg::DivNW-1:0]  num_i,
  input  logic [ecp_pkg::DivDW-1:0]  den_i,
  input  ecp_pkg::ecp_side_t         side_i,
  output logic                       valid_o,
  output logic [ecp_pkg::DivQW-1:0]  quo_o,
  output ecp_pkg::ecp_side_t         side_o
);
  import ecp_pkg::*;

  logic [DivQW-1:0] v_q;
  logic [DivQW-1:0] quo_q  [DivQW];
  ecp_side_t        side_q [DivQW];
  logic [DivNW-1:0] rem_q  [DivQW-1];
  logic [DivDW-1:0] den_q  [DivQW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivQW-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < DivQW; k++) begin : g_stage
    logic [DivNW-1:0] rem_in;
    logic [DivDW-1:0] den_in;
    logic [DivQW-1:0] quo_in;
    ecp_side_t        side_in;
    logic [DivNW-1:0] sub;
    logic [DivNW:0]   diff;
    logic             ge;
    logic [DivQW-1:0] quo_nx;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign sub  = {{(DivNW-DivDW){1'b0}}, den_in} << (DivQW-1-k);
    assign diff = {1'b0, rem_in} - {1'b0, sub};
    assign ge   = !diff[DivNW];

    always_comb begin
      quo_nx = quo_in;
      quo_nx[DivQW-1-k] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k]  <= quo_nx;
        side_q[k] <= side_in;
      end
    end

    if (k < DivQW-1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff[DivNW-1:0] : rem_in;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign valid_o = v_q[DivQW-1];
  assign quo_o   = quo_q[DivQW-1];
  assign side_o  = side_q[DivQW-1];
endmodule

FILE: hdl/ecp_impulse.sv
// ----------------------------------------------------------------------------
// Impulse weighting stage
// Scales both projections by twice the opposite mass and forms the mass
// denominator for the second division.
// ----------------------------------------------------------------------------
module ecp_impulse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [ecp_pkg::DivQW-1:0]  sx_i,
  input  logic [ecp_pkg::DivQW-1:0]  sy_i,
  input  ecp_pkg::ecp_side_t         side_i,
  output logic                       valid_o,
  output logic [ecp_pkg::DivNW-1:0]  num_ax_o,
  output logic [ecp_pkg::DivNW-1:0]  num_ay_o,
  output logic [ecp_pkg::DivNW-1:0]  num_bx_o,
  output logic [ecp_pkg::DivNW-1:0]  num_by_o,
  output logic [ecp_pkg::DivDW-1:0]  den_o,
  output ecp_pkg::ecp_side_t         side_o
);
  import ecp_pkg::*;

  localparam int unsigned PrW = MassW + DivQW;

  logic             v_q;
  logic [PrW-1:0]   pax_q, pay_q, pbx_q, pby_q;
  logic [MassW:0]   msum_q;
  ecp_side_t        side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pax_q  <= side_i.mb * sx_i;
      pay_q  <= side_i.mb * sy_i;
      pbx_q  <= side_i.ma * sx_i;
      pby_q  <= side_i.ma * sy_i;
      msum_q <= {1'b0, side_i.ma} + {1'b0, side_i.mb};
      side_q <= side_i;
    end
  end

  assign valid_o  = v_q;
  assign num_ax_o = {{(DivNW-PrW-1){1'b0}}, pax_q, 1'b0};
  assign num_ay_o = {{(DivNW-PrW-1){1'b0}}, pay_q, 1'b0};
  assign num_bx_o = {{(DivNW-PrW-1){1'b0}}, pbx_q, 1'b0};
  assign num_by_o = {{(DivNW-PrW-1){1'b0}}, pby_q, 1'b0};
  assign den_o    = {{(DivDW-MassW-9){1'b0}}, msum_q, 8'd0};
  assign side_o   = side_q;
endmodule

FILE: hdl/ecp_update.sv
// ----------------------------------------------------------------------------
// Velocity update stage
// Applies signed deltas, saturates to Q8.8 and registers the result beat.
// ----------------------------------------------------------------------------
module ecp_update (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [ecp_pkg::DivQW-1:0]  dax_i,
  input  logic [ecp_pkg::DivQW-1:0]  day_i,
  input  logic [ecp_pkg::DivQW-1:0]  dbx_i,
  input  logic [ecp_pkg::DivQW-1:0]  dby_i,
  input  ecp_pkg::ecp_side_t         side_i,
  output logic                       valid_o,
  output ecp_pkg::ecp_res_t          res_o
);
  import ecp_pkg::*;

  function automatic logic [VelW-1:0] apply(input logic [VelW-1:0] v,
                                            input logic [DivQW-1:0] q,
                                            input logic neg);
    logic [DivQW:0]   dl;
    logic [DivQW+1:0] sum;
    logic [VelW-1:0]  r;
    dl  = neg ? ((DivQW+1)'(0) - {1'b0, q}) : {1'b0, q};
    sum = {{(DivQW+2-VelW){v[VelW-1]}}, v} + {dl[DivQW], dl};
    if (!sum[DivQW+1] && (sum[DivQW:VelW-1] != '0)) begin
      r = {1'b0, {(VelW-1){1'b1}}};
    end else if (sum[DivQW+1] && (sum[DivQW:VelW-1] != '1)) begin
      r = {1'b1, {(VelW-1){1'b0}}};
    end else begin
      r = sum[VelW-1:0];
    end
    return r;
  endfunction

  logic     v_q;
  ecp_res_t res_q, res_d;

  always_comb begin
    res_d.id_a    = side_i.id_a;
    res_d.id_b    = side_i.id_b;
    res_d.bounced = side_i.go;
    if (side_i.go) begin
      res_d.nax = apply(side_i.avx, dax_i, side_i.neg_x);
      res_d.nay = apply(side_i.avy, day_i, side_i.neg_y);
      res_d.nbx = apply(side_i.bvx, dbx_i, !side_i.neg_x);
      res_d.nby = apply(side_i.bvy, dby_i, !side_i.neg_y);
    end else begin
      res_d.nax = side_i.avx;
      res_d.nay = side_i.avy;
      res_d.nbx = side_i.bvx;
      res_d.nby = side_i.bvy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = v_q;
  assign res_o   = res_q;
endmodule

FILE: hdl/ecp_skid.sv
// ----------------------------------------------------------------------------
// Output skid buffer
// Two-entry result queue; freezes the pipeline only when both entries hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ecp_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ecp_pkg::ecp_res_t  res_i,
  input  logic               stall_i,
  output logic               en_o,
  output logic               valid_o,
  output ecp_pkg::ecp_res_t  res_o
);
  import ecp_pkg::*;

  ecp_res_t   buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign en_o    = (cnt_q != 2'd2);
  assign push    = valid_i && en_o;
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && !stall_i;
  assign res_o   = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= res_i;
  end

  `ECP_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3)
  `ECP_ASSERT(a_cnt_up, clk_i, rst_ni, (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
  `ECP_ASSERT(a_cnt_dn, clk_i, rst_ni, (pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1)
  `ECP_ASSERT(a_ptr_gap, clk_i, rst_ni, (cnt_q == 2'd1) |-> (wr_q != rd_q))
endmodule

FILE: hdl/elastic_collision_2d_pair.sv
// ----------------------------------------------------------------------------
// Two-disc elastic collision resolver
// Contact and approach test with elastic impulse along the center line.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one disc pair per beat.
// Output channel: out_valid_o / out_stall_i carry one result beat per pair,
// in order. Config channel: cfg_valid_i / cfg_ready_o writes disc_radius
// (always ready); write it only while no pair is in flight.
// Throughput: one pair per cycle while the pipeline is not frozen. An input beat
// reaches its result beat through six front stages, two 26-stage bit-per-cycle
// dividers, one mass weighting stage, one update stage and the output buffer.
// Reset clears all valid bits and loads disc_radius with 10.0 (2560).
// When the receiver stalls, results collect in a two-entry output buffer;
// once both entries hold, the whole pipeline freezes and in_stall_o rises.
// Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module elastic_collision_2d_pair (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ecp_pkg::RadW-1:0]           cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ecp_pkg::IdW-1:0]            ball_a_id_i,
  input  logic [ecp_pkg::IdW-1:0]            ball_b_id_i,
  input  logic signed [ecp_pkg::PosW-1:0]    a_pos_x_i,
  input  logic signed [ecp_pkg::PosW-1:0]    a_pos_y_i,
  input  logic signed [ecp_pkg::VelW-1:0]    a_vel_x_i,
  input  logic signed [ecp_pkg::VelW-1:0]    a_vel_y_i,
  input  logic [ecp_pkg::MassW-1:0]          a_mass_i,
  input  logic signed [ecp_pkg::PosW-1:0]    b_pos_x_i,
  input  logic signed [ecp_pkg::PosW-1:0]    b_pos_y_i,
  input  logic signed [ecp_pkg::VelW-1:0]    b_vel_x_i,
  input  logic signed [ecp_pkg::VelW-1:0]    b_vel_y_i,
  input  logic [ecp_pkg::MassW-1:0]          b_mass_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ecp_pkg::IdW-1:0]            out_a_id_o,
  output logic [ecp_pkg::IdW-1:0]            out_b_id_o,
  output logic signed [ecp_pkg::VelW-1:0]    new_a_vel_x_o,
  output logic signed [ecp_pkg::VelW-1:0]    new_a_vel_y_o,
  output logic signed [ecp_pkg::VelW-1:0]    new_b_vel_x_o,
  output logic signed [ecp_pkg::VelW-1:0]    new_b_vel_y_o,
  output logic                               bounced_o
);
  import ecp_pkg::*;

  logic [RadW-1:0]  radius_q;
  logic             en;
  ecp_pair_t        pair;

  logic             fr_valid;
  logic [DivNW-1:0] fr_num_x, fr_num_y;
  logic [DivDW-1:0] fr_den;
  ecp_side_t        fr_side;

  logic             d1_valid;
  logic [DivQW-1:0] d1_sx, d1_sy;
  ecp_side_t        d1_side;

  logic             im_valid;
  logic [DivNW-1:0] im_ax, im_ay, im_bx, im_by;
  logic [DivDW-1:0] im_den;
  ecp_side_t        im_side;

  logic             d2_valid;
  logic [DivQW-1:0] d2_ax, d2_ay, d2_bx, d2_by;
  ecp_side_t        d2_side;

  logic             up_valid;
  ecp_res_t         up_res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_data_i;
    end
  end

  assign in_stall_o = !en;

  always_comb begin
    pair.id_a = ball_a_id_i;
    pair.id_b = ball_b_id_i;
    pair.apx  = a_pos_x_i;
    pair.apy  = a_pos_y_i;
    pair.avx  = a_vel_x_i;
    pair.avy  = a_vel_y_i;
    pair.am   = a_mass_i;
    pair.bpx  = b_pos_x_i;
    pair.bpy  = b_pos_y_i;
    pair.bvx  = b_vel_x_i;
    pair.bvy  = b_vel_y_i;
    pair.bm   = b_mass_i;
  end

  ecp_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .radius_i(radius_q),
    .pair_i(pair), .valid_o(fr_valid), .num_x_o(fr_num_x), .num_y_o(fr_num_y),
    .den_o(fr_den), .side_o(fr_side)
  );

  ecp_div u_div_sx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_valid), .num_i(fr_num_x),
    .den_i(fr_den), .side_i(fr_side), .valid_o(d1_valid), .quo_o(d1_sx),
    .side_o(d1_side)
  );

  ecp_div u_div_sy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_valid), .num_i(fr_num_y),
    .den_i(fr_den), .side_i(fr_side), .valid_o(), .quo_o(d1_sy), .side_o()
  );

  ecp_impulse u_impulse (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d1_valid), .sx_i(d1_sx), .sy_i(d1_sy),
    .side_i(d1_side), .valid_o(im_valid), .num_ax_o(im_ax), .num_ay_o(im_ay),
    .num_bx_o(im_bx), .num_by_o(im_by), .den_o(im_den), .side_o(im_side)
  );

  ecp_div u_div_ax (
    .clk_i, .rst_ni, .en_i(en), .valid_i(im_valid), .num_i(im_ax),
    .den_i(im_den), .side_i(im_side), .valid_o(d2_valid), .quo_o(d2_ax),
    .side_o(d2_side)
  );

  ecp_div u_div_ay (
    .clk_i, .rst_ni, .en_i(en), .valid_i(im_valid), .num_i(im_ay),
    .den_i(im_den), .side_i(im_side), .valid_o(), .quo_o(d2_ay), .side_o()
  );

  ecp_div u_div_bx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(im_valid), .num_i(im_bx),
    .den_i(im_den), .side_i(im_side), .valid_o(), .quo_o(d2_bx), .side_o()
  );

  ecp_div u_div_by (
    .clk_i, .rst_ni, .en_i(en), .valid_i(im_valid), .num_i(im_by),
    .den_i(im_den), .side_i(im_side), .valid_o(), .quo_o(d2_by), .side_o()
  );

  ecp_update u_update (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d2_valid), .dax_i(d2_ax), .day_i(d2_ay),
    .dbx_i(d2_bx), .dby_i(d2_by), .side_i(d2_side), .valid_o(up_valid),
    .res_o(up_res)
  );

  ecp_skid u_skid (
    .clk_i, .rst_ni, .valid_i(up_valid), .res_i(up_res), .stall_i(out_stall_i),
    .en_o(en), .valid_o(out_valid_o), .res_o(out_res)
  );

  assign out_a_id_o    = out_res.id_a;
  assign out_b_id_o    = out_res.id_b;
  assign new_a_vel_x_o = out_res.nax;
  assign new_a_vel_y_o = out_res.nay;
  assign new_b_vel_x_o = out_res.nbx;
  assign new_b_vel_y_o = out_res.nby;
  assign bounced_o     = out_res.bounced;
endmodule
